>>> hdl/lph_pkg.sv
// Shared types, constants and helper functions of the literal priority heap.
`default_nettype none
package lph_pkg;

    localparam int MAX_VARS = 256;
    localparam int NLIT     = 2 * MAX_VARS;
    localparam int PRIO_W   = 32;
    localparam int TOTAL_W  = PRIO_W + 8;
    localparam int VC_W     = $clog2(MAX_VARS + 1);
    localparam int LIT_W    = $clog2(NLIT);
    localparam int SLOT_W   = $clog2(NLIT + 1);
    localparam int LITV_W   = 10;
    localparam int CNT_W    = 10;
    localparam int STS_W    = 2;
    localparam int OP_W     = 3;
    localparam int CFG_W    = 32;
    localparam int CIDX_W   = 2;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 56;
    localparam logic [PRIO_W-1:0] ONE_FIX = PRIO_W'(65536);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD    = 3'd0,
        OP_BUILD   = 3'd1,
        OP_EXTRACT = 3'd2,
        OP_RESTORE = 3'd3,
        OP_BUMP    = 3'd4
    } op_t;

    typedef enum logic [STS_W-1:0] {
        STS_DONE    = 2'd0,
        STS_IGNORED = 2'd1,
        STS_RANGE   = 2'd2
    } status_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_VAR_COUNT     = 2'd0,
        CFG_BUMP_FACTOR   = 2'd1,
        CFG_BALANCE_LIMIT = 2'd2,
        CFG_BALANCE_FLOOR = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              rem;
        logic [PRIO_W-1:0] prio;
    } lit_word_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_OP, ST_BUMP_MUL, ST_BUMP_ADD,
        ST_RB_CHK, ST_RB_RD, ST_RB_MUL, ST_RB_DIV, ST_RB_WAIT, ST_BUILD_NEXT,
        ST_SD_START, ST_SD_CUR, ST_SD_CURK, ST_SD_L, ST_SD_LW, ST_SD_LK,
        ST_SD_RK, ST_SD_DEC, ST_SD_SW2,
        ST_SU_START, ST_SU_CUR, ST_SU_CURK, ST_SU_P, ST_SU_PW, ST_SU_PK,
        ST_SU_SW2, ST_FIN_RD, ST_FIN_WAIT
    } state_t;

    // True when key a orders strictly below key b; removed keys sink below active ones.
    function automatic logic key_less(input logic a_rem, input logic [PRIO_W-1:0] a_p,
                                      input logic b_rem, input logic [PRIO_W-1:0] b_p);
        logic r;
        if (a_rem != b_rem) begin
            r = a_rem;
        end else if (!a_rem) begin
            r = a_p < b_p;
        end else begin
            r = a_p > b_p;
        end
        return r;
    endfunction

    function automatic logic [LITV_W-1:0] encode_lit(input logic [LIT_W-1:0] idx);
        logic [LITV_W-1:0] mag;
        mag = LITV_W'(idx >> 1) + LITV_W'(1);
        return idx[0] ? (LITV_W'(0) - mag) : mag;
    endfunction

endpackage
`default_nettype wire

>>> hdl/lph_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module lph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> hdl/lph_div.sv
// Bit-serial restoring divider with a saturated quotient, used for rescaling.
`default_nettype none
module lph_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [2*lph_pkg::PRIO_W-1:0] dividend,
    input  logic [lph_pkg::TOTAL_W-1:0] divisor,
    output logic                        done,
    output logic [lph_pkg::PRIO_W-1:0]  quotient
);
    import lph_pkg::*;

    localparam int DW = 2 * PRIO_W;
    localparam int CW = $clog2(DW);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [DW-1:0]       dvd_reg, dvd_next;
    logic [DW-1:0]       quo_reg, quo_next;
    logic [TOTAL_W-1:0]  rem_reg, rem_next;
    logic [TOTAL_W-1:0]  dvs_reg, dvs_next;
    logic [TOTAL_W:0]    trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, dvd_reg[DW-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            quo_next  = '0;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[DW-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = TOTAL_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end else begin
                rem_next = trial[TOTAL_W-1:0];
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(DW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = (quo_reg[DW-1:PRIO_W] != '0) ? '1 : quo_reg[PRIO_W-1:0];

    a_done_single: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> !done) else $error("divider done held longer than one cycle");
    a_busy_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> !busy_reg) else $error("divider done while still busy");
    a_rem_below: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg && !start |-> rem_reg < dvs_reg || dvs_reg == '0)
        else $error("divider remainder reached divisor");

endmodule
`default_nettype wire

>>> hdl/literal_priority_heap_core.sv
// Top level of the literal priority heap: control sequencer, memories and stream ports.
`default_nettype none
// The block keeps an indexed max-heap of up to 512 signed literals in two
// one-port-read RAMs (slot-to-literal and literal-to-{slot, mark, priority})
// and answers every word with one result word. Extract and restore walk the
// heap level by level, and bump runs a multiply, a sift-up and a sift-down
// and then a rescale check; each access along the sift path is one RAM read
// and one write. A build runs a rescale check and then a sift-down for every
// internal slot. A rescale visits every literal with a bit-serial divide.
// After reset and after each var_count write a clearing pass over all 512
// entries fills the RAMs; no word is taken then.
module literal_priority_heap_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [lph_pkg::CIDX_W-1:0]    cfg_wr_index,
    input  logic [lph_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // literal [9:0]
    input  logic [lph_pkg::S_DATA_W-1:0]  s_tdata,
    // operation [2:0]
    input  logic [lph_pkg::OP_W-1:0]      s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // top_literal [9:0], literal_priority [41:10], literal_removed [42],
    // active_count [52:43]
    output logic [lph_pkg::M_DATA_W-1:0]  m_tdata,
    // status [1:0]
    output logic [lph_pkg::STS_W-1:0]     m_tuser
);
    import lph_pkg::*;

    state_t             state_reg, state_next;
    logic [LIT_W-1:0]   iter_reg, iter_next;
    logic [VC_W-1:0]    vc_reg, vc_next;
    logic [PRIO_W-1:0]  factor_reg, factor_next;
    logic [15:0]        limit_reg, limit_next;
    logic [15:0]        floor_reg, floor_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic [TOTAL_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]   live_reg, live_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [LIT_W-1:0]   idx_reg, idx_next;
    logic               named_reg, named_next;
    status_t            status_reg, status_next;
    logic [SLOT_W-1:0]  pos_reg, pos_next;
    logic [LIT_W-1:0]   cur_lit_reg, cur_lit_next;
    logic               cur_rem_reg, cur_rem_next;
    logic [PRIO_W-1:0]  cur_prio_reg, cur_prio_next;
    logic [LIT_W-1:0]   l_lit_reg, l_lit_next;
    logic               l_rem_reg, l_rem_next;
    logic [PRIO_W-1:0]  l_prio_reg, l_prio_next;
    logic [LIT_W-1:0]   r_lit_reg, r_lit_next;
    logic               r_rem_reg, r_rem_next;
    logic [PRIO_W-1:0]  r_prio_reg, r_prio_next;
    logic               has_r_reg, has_r_next;
    logic [2*PRIO_W-1:0] prod_reg;
    logic [PRIO_W-1:0]  mul_a, mul_b;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [STS_W-1:0]   m_tuser_reg, m_tuser_next;

    logic               heap_we;
    logic [LIT_W-1:0]   heap_waddr, heap_wdata, heap_raddr, heap_rdata;
    logic               lit_we;
    logic [LIT_W-1:0]   lit_waddr, lit_raddr;
    lit_word_t          lit_wdata, lit_rdata;

    logic               div_start, div_done;
    logic [PRIO_W-1:0]  div_quo;

    // Input decode.
    logic [LITV_W-1:0]  in_raw, in_mag, in_mag_m1;
    logic               in_neg, in_bad, in_acc;
    logic [LIT_W-1:0]   in_idx;
    op_t                in_op;

    // Shared datapath terms.
    logic [SLOT_W-1:0]  n_lits;
    logic [SLOT_W:0]    l_slot;
    logic               l_over, best_r, sd_swap, su_swap, rb_need, rb_last, out_load;
    logic [LIT_W-1:0]   best_lit;
    logic               best_rem;
    logic [PRIO_W-1:0]  best_prio;
    logic [SLOT_W-1:0]  best_slot, par_slot;
    logic [PRIO_W:0]    load_sum;
    logic [TOTAL_W:0]   tot_inc, tot_bump, sum_inc;
    logic [PRIO_W-1:0]  bump_new;
    logic [VC_W-1:0]    cfg_vc;
    state_t             sd_exit, su_exit, rb_exit;

    assign in_raw    = s_tdata[LITV_W-1:0];
    assign in_neg    = in_raw[LITV_W-1];
    assign in_mag    = in_neg ? (LITV_W'(0) - in_raw) : in_raw;
    assign in_mag_m1 = in_mag - LITV_W'(1);
    assign in_bad    = (in_mag == '0) || (in_mag > LITV_W'(vc_reg));
    assign in_idx    = {in_mag_m1[LIT_W-2:0], in_neg};
    assign in_op     = op_t'(s_tuser);
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;

    assign n_lits    = {vc_reg, 1'b0};
    assign l_slot    = {pos_reg, 1'b0};
    assign l_over    = l_slot > {1'b0, n_lits};
    assign best_r    = has_r_reg && key_less(l_rem_reg, l_prio_reg, r_rem_reg, r_prio_reg);
    assign best_lit  = best_r ? r_lit_reg : l_lit_reg;
    assign best_rem  = best_r ? r_rem_reg : l_rem_reg;
    assign best_prio = best_r ? r_prio_reg : l_prio_reg;
    assign best_slot = l_slot[SLOT_W-1:0] + SLOT_W'(best_r);
    assign sd_swap   = key_less(cur_rem_reg, cur_prio_reg, best_rem, best_prio);
    assign su_swap   = key_less(lit_rdata.rem, lit_rdata.prio, cur_rem_reg, cur_prio_reg);
    assign par_slot  = pos_reg >> 1;
    assign rb_need   = (total_reg != '0) &&
                       ((total_reg < TOTAL_W'(floor_reg)) ||
                        (total_reg > TOTAL_W'({limit_reg, 16'd0})));
    assign rb_last   = {1'b0, iter_reg} == (n_lits - SLOT_W'(1));
    assign out_load  = (state_reg == ST_FIN_WAIT) && (!m_tvalid_reg || m_tready);

    assign load_sum  = {1'b0, lit_rdata.prio} + {1'b0, ONE_FIX};
    assign tot_inc   = {1'b0, total_reg} + (TOTAL_W + 1)'(ONE_FIX);
    assign tot_bump  = {1'b0, total_reg} + (TOTAL_W + 1)'(cur_prio_reg);
    assign sum_inc   = {1'b0, sum_reg} + (TOTAL_W + 1)'(div_quo);
    assign bump_new  = (prod_reg[2*PRIO_W-1:PRIO_W+16] != '0) ? '1 : prod_reg[PRIO_W+15:16];

    assign cfg_vc    = (cfg_wr_data[VC_W-1:0] == '0) ? VC_W'(1) :
                       (cfg_wr_data[VC_W-1:0] > VC_W'(MAX_VARS)) ? VC_W'(MAX_VARS) :
                       cfg_wr_data[VC_W-1:0];

    assign sd_exit   = (op_reg == OP_BUMP)  ? ST_RB_CHK :
                       (op_reg == OP_BUILD) ? ST_BUILD_NEXT : ST_FIN_RD;
    assign su_exit   = (op_reg == OP_BUMP)  ? ST_SD_START : ST_FIN_RD;
    assign rb_exit   = (op_reg == OP_BUILD) ? ST_BUILD_NEXT : ST_FIN_RD;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:      if (iter_reg == '1) state_next = ST_IDLE;
            ST_IDLE: begin
                if (in_acc) begin
                    if (in_op == OP_BUILD) begin
                        state_next = ST_RB_CHK;
                    end else if (s_tuser > OP_BUMP || in_bad) begin
                        state_next = ST_FIN_RD;
                    end else begin
                        state_next = ST_OP;
                    end
                end
            end
            ST_OP: begin
                unique case (op_reg)
                    OP_EXTRACT: state_next = lit_rdata.rem ? ST_FIN_RD : ST_SD_START;
                    OP_RESTORE: state_next = lit_rdata.rem ? ST_SU_START : ST_FIN_RD;
                    OP_BUMP:    state_next = ST_BUMP_MUL;
                    default:    state_next = ST_FIN_RD;
                endcase
            end
            ST_BUMP_MUL:   state_next = ST_BUMP_ADD;
            ST_BUMP_ADD:   state_next = ST_SU_START;
            ST_RB_CHK:     state_next = rb_need ? ST_RB_RD : rb_exit;
            ST_RB_RD:      state_next = ST_RB_MUL;
            ST_RB_MUL:     state_next = ST_RB_DIV;
            ST_RB_DIV:     state_next = ST_RB_WAIT;
            ST_RB_WAIT:    if (div_done) state_next = rb_last ? rb_exit : ST_RB_RD;
            ST_BUILD_NEXT: state_next = (iter_reg == '0) ? ST_FIN_RD : ST_SD_START;
            ST_SD_START:   state_next = ST_SD_CUR;
            ST_SD_CUR:     state_next = ST_SD_CURK;
            ST_SD_CURK:    state_next = ST_SD_L;
            ST_SD_L:       state_next = l_over ? sd_exit : ST_SD_LW;
            ST_SD_LW:      state_next = ST_SD_LK;
            ST_SD_LK:      state_next = has_r_reg ? ST_SD_RK : ST_SD_DEC;
            ST_SD_RK:      state_next = ST_SD_DEC;
            ST_SD_DEC:     state_next = sd_swap ? ST_SD_SW2 : sd_exit;
            ST_SD_SW2:     state_next = ST_SD_L;
            ST_SU_START:   state_next = ST_SU_CUR;
            ST_SU_CUR:     state_next = ST_SU_CURK;
            ST_SU_CURK:    state_next = ST_SU_P;
            ST_SU_P:       state_next = (pos_reg <= SLOT_W'(1)) ? su_exit : ST_SU_PW;
            ST_SU_PW:      state_next = ST_SU_PK;
            ST_SU_PK:      state_next = su_swap ? ST_SU_SW2 : su_exit;
            ST_SU_SW2:     state_next = ST_SU_P;
            ST_FIN_RD:     state_next = ST_FIN_WAIT;
            ST_FIN_WAIT:   if (out_load) state_next = ST_IDLE;
            default:       state_next = ST_CLEAR;
        endcase
        if (cfg_wr_en && cfg_idx_t'(cfg_wr_index) == CFG_VAR_COUNT) begin
            state_next = ST_CLEAR;
        end
    end

    // Datapath and memory control.
    always_comb begin
        iter_next     = iter_reg;
        vc_next       = vc_reg;
        factor_next   = factor_reg;
        limit_next    = limit_reg;
        floor_next    = floor_reg;
        total_next    = total_reg;
        sum_next      = sum_reg;
        live_next     = live_reg;
        op_next       = op_reg;
        idx_next      = idx_reg;
        named_next    = named_reg;
        status_next   = status_reg;
        pos_next      = pos_reg;
        cur_lit_next  = cur_lit_reg;
        cur_rem_next  = cur_rem_reg;
        cur_prio_next = cur_prio_reg;
        l_lit_next    = l_lit_reg;
        l_rem_next    = l_rem_reg;
        l_prio_next   = l_prio_reg;
        r_lit_next    = r_lit_reg;
        r_rem_next    = r_rem_reg;
        r_prio_next   = r_prio_reg;
        has_r_next    = has_r_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        mul_a         = lit_rdata.prio;
        mul_b         = factor_reg;
        div_start     = 1'b0;
        heap_we       = 1'b0;
        heap_waddr    = '0;
        heap_wdata    = '0;
        heap_raddr    = '0;
        lit_we        = 1'b0;
        lit_waddr     = '0;
        lit_wdata     = '0;
        lit_raddr     = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                heap_we    = 1'b1;
                heap_waddr = iter_reg;
                heap_wdata = iter_reg;
                lit_we     = 1'b1;
                lit_waddr  = iter_reg;
                lit_wdata  = '{slot: SLOT_W'(iter_reg) + SLOT_W'(1), rem: 1'b0, prio: '0};
                iter_next  = iter_reg + LIT_W'(1);
            end
            ST_IDLE: begin
                lit_raddr = in_idx;
                if (in_acc) begin
                    op_next     = s_tuser;
                    idx_next    = in_idx;
                    named_next  = 1'b0;
                    status_next = STS_DONE;
                    if (in_op == OP_BUILD) begin
                        status_next = STS_DONE;
                    end else if (s_tuser > OP_BUMP) begin
                        status_next = STS_IGNORED;
                    end else if (in_bad) begin
                        status_next = STS_RANGE;
                    end else begin
                        named_next = 1'b1;
                    end
                end
            end
            ST_OP: begin
                pos_next      = lit_rdata.slot;
                cur_rem_next  = lit_rdata.rem;
                cur_prio_next = lit_rdata.prio;
                lit_waddr     = idx_reg;
                lit_wdata     = lit_rdata;
                unique case (op_reg)
                    OP_LOAD: begin
                        lit_we         = 1'b1;
                        lit_wdata.prio = load_sum[PRIO_W] ? '1 : load_sum[PRIO_W-1:0];
                        total_next     = tot_inc[TOTAL_W] ? '1 : tot_inc[TOTAL_W-1:0];
                    end
                    OP_EXTRACT: begin
                        if (lit_rdata.rem) begin
                            status_next = STS_IGNORED;
                        end else begin
                            lit_we        = 1'b1;
                            lit_wdata.rem = 1'b1;
                            live_next     = live_reg - CNT_W'(1);
                        end
                    end
                    OP_RESTORE: begin
                        if (!lit_rdata.rem) begin
                            status_next = STS_IGNORED;
                        end else begin
                            lit_we        = 1'b1;
                            lit_wdata.rem = 1'b0;
                            live_next     = live_reg + CNT_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_BUMP_MUL: begin
                lit_we        = 1'b1;
                lit_waddr     = idx_reg;
                lit_wdata     = '{slot: pos_reg, rem: cur_rem_reg, prio: bump_new};
                total_next    = (total_reg > TOTAL_W'(cur_prio_reg)) ?
                                total_reg - TOTAL_W'(cur_prio_reg) : '0;
                cur_prio_next = bump_new;
            end
            ST_BUMP_ADD: begin
                total_next = tot_bump[TOTAL_W] ? '1 : tot_bump[TOTAL_W-1:0];
            end
            ST_RB_CHK: begin
                iter_next = '0;
                sum_next  = '0;
                if (!rb_need && op_reg == OP_BUILD) begin
                    iter_next = LIT_W'(vc_reg);
                end
            end
            ST_RB_RD: begin
                lit_raddr = iter_reg;
            end
            ST_RB_MUL: begin
                mul_b        = {limit_reg, 16'd0};
                pos_next     = lit_rdata.slot;
                cur_rem_next = lit_rdata.rem;
            end
            ST_RB_DIV: begin
                div_start = 1'b1;
            end
            ST_RB_WAIT: begin
                if (div_done) begin
                    lit_we    = 1'b1;
                    lit_waddr = iter_reg;
                    lit_wdata = '{slot: pos_reg, rem: cur_rem_reg, prio: div_quo};
                    sum_next  = sum_inc[TOTAL_W] ? '1 : sum_inc[TOTAL_W-1:0];
                    iter_next = iter_reg + LIT_W'(1);
                    if (rb_last) begin
                        total_next = sum_inc[TOTAL_W] ? '1 : sum_inc[TOTAL_W-1:0];
                        if (op_reg == OP_BUILD) begin
                            iter_next = LIT_W'(vc_reg);
                        end
                    end
                end
            end
            ST_BUILD_NEXT: begin
                pos_next = SLOT_W'(iter_reg);
            end
            ST_SD_START, ST_SU_START: begin
                heap_raddr = LIT_W'(pos_reg - SLOT_W'(1));
            end
            ST_SD_CUR, ST_SU_CUR: begin
                cur_lit_next = heap_rdata;
                lit_raddr    = heap_rdata;
            end
            ST_SD_CURK, ST_SU_CURK: begin
                cur_rem_next  = lit_rdata.rem;
                cur_prio_next = lit_rdata.prio;
            end
            ST_SD_L: begin
                heap_raddr = LIT_W'(l_slot - (SLOT_W + 1)'(1));
                if (l_over && op_reg == OP_BUILD) begin
                    iter_next = iter_reg - LIT_W'(1);
                end
            end
            ST_SD_LW: begin
                l_lit_next = heap_rdata;
                lit_raddr  = heap_rdata;
                has_r_next = l_slot < {1'b0, n_lits};
                heap_raddr = l_slot[LIT_W-1:0];
            end
            ST_SD_LK: begin
                l_rem_next  = lit_rdata.rem;
                l_prio_next = lit_rdata.prio;
                r_lit_next  = heap_rdata;
                lit_raddr   = heap_rdata;
            end
            ST_SD_RK: begin
                r_rem_next  = lit_rdata.rem;
                r_prio_next = lit_rdata.prio;
            end
            ST_SD_DEC: begin
                if (sd_swap) begin
                    heap_we    = 1'b1;
                    heap_waddr = LIT_W'(pos_reg - SLOT_W'(1));
                    heap_wdata = best_lit;
                    lit_we     = 1'b1;
                    lit_waddr  = best_lit;
                    lit_wdata  = '{slot: pos_reg, rem: best_rem, prio: best_prio};
                    pos_next   = best_slot;
                end else if (op_reg == OP_BUILD) begin
                    iter_next = iter_reg - LIT_W'(1);
                end
            end
            ST_SD_SW2: begin
                heap_we    = 1'b1;
                heap_waddr = LIT_W'(pos_reg - SLOT_W'(1));
                heap_wdata = cur_lit_reg;
                lit_we     = 1'b1;
                lit_waddr  = cur_lit_reg;
                lit_wdata  = '{slot: pos_reg, rem: cur_rem_reg, prio: cur_prio_reg};
            end
            ST_SU_P: begin
                heap_raddr = LIT_W'(par_slot - SLOT_W'(1));
            end
            ST_SU_PW: begin
                l_lit_next = heap_rdata;
                lit_raddr  = heap_rdata;
            end
            ST_SU_PK: begin
                l_rem_next  = lit_rdata.rem;
                l_prio_next = lit_rdata.prio;
                if (su_swap) begin
                    heap_we    = 1'b1;
                    heap_waddr = LIT_W'(par_slot - SLOT_W'(1));
                    heap_wdata = cur_lit_reg;
                    lit_we     = 1'b1;
                    lit_waddr  = cur_lit_reg;
                    lit_wdata  = '{slot: par_slot, rem: cur_rem_reg, prio: cur_prio_reg};
                end
            end
            ST_SU_SW2: begin
                heap_we    = 1'b1;
                heap_waddr = LIT_W'(pos_reg - SLOT_W'(1));
                heap_wdata = l_lit_reg;
                lit_we     = 1'b1;
                lit_waddr  = l_lit_reg;
                lit_wdata  = '{slot: pos_reg, rem: l_rem_reg, prio: l_prio_reg};
                pos_next   = par_slot;
            end
            ST_FIN_RD, ST_FIN_WAIT: begin
                heap_raddr = '0;
                lit_raddr  = idx_reg;
                if (out_load) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = status_reg;
                    m_tdata_next  = {
                        3'd0,
                        live_reg,
                        named_reg && lit_rdata.rem,
                        named_reg ? lit_rdata.prio : PRIO_W'(0),
                        encode_lit(heap_rdata)
                    };
                end
            end
            default: begin
            end
        endcase

        if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_wr_index))
                CFG_VAR_COUNT: begin
                    vc_next    = cfg_vc;
                    iter_next  = '0;
                    total_next = '0;
                    live_next  = CNT_W'({cfg_vc, 1'b0});
                end
                CFG_BUMP_FACTOR:   factor_next = cfg_wr_data;
                CFG_BALANCE_LIMIT: limit_next  = cfg_wr_data[15:0];
                CFG_BALANCE_FLOOR: floor_next  = cfg_wr_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            iter_reg     <= '0;
            vc_reg       <= VC_W'(MAX_VARS);
            factor_reg   <= PRIO_W'(68813);
            limit_reg    <= 16'd65535;
            floor_reg    <= 16'd1;
            total_reg    <= '0;
            live_reg     <= CNT_W'(2 * MAX_VARS);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            iter_reg     <= iter_next;
            vc_reg       <= vc_next;
            factor_reg   <= factor_next;
            limit_reg    <= limit_next;
            floor_reg    <= floor_next;
            total_reg    <= total_next;
            live_reg     <= live_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        sum_reg      <= sum_next;
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        named_reg    <= named_next;
        status_reg   <= status_next;
        pos_reg      <= pos_next;
        cur_lit_reg  <= cur_lit_next;
        cur_rem_reg  <= cur_rem_next;
        cur_prio_reg <= cur_prio_next;
        l_lit_reg    <= l_lit_next;
        l_rem_reg    <= l_rem_next;
        l_prio_reg   <= l_prio_next;
        r_lit_reg    <= r_lit_next;
        r_rem_reg    <= r_rem_next;
        r_prio_reg   <= r_prio_next;
        has_r_reg    <= has_r_next;
        prod_reg     <= mul_a * mul_b;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    lph_ram #(.WIDTH(LIT_W), .DEPTH(NLIT)) u_heap_ram (
        .aclk  (aclk),
        .we    (heap_we),
        .waddr (heap_waddr),
        .wdata (heap_wdata),
        .raddr (heap_raddr),
        .rdata (heap_rdata)
    );

    lph_ram #(.WIDTH($bits(lit_word_t)), .DEPTH(NLIT)) u_lit_ram (
        .aclk  (aclk),
        .we    (lit_we),
        .waddr (lit_waddr),
        .wdata (lit_wdata),
        .raddr (lit_raddr),
        .rdata (lit_rdata)
    );

    lph_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (total_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= CNT_W'({vc_reg, 1'b0})) else $error("active count above literal count");
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_tready) else $error("second word taken while one is in work");
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_FIN_WAIT))
        else $error("result word raised outside the finish state");
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> (m_tuser_reg == STS_DONE || m_tuser_reg == STS_IGNORED ||
                          m_tuser_reg == STS_RANGE)) else $error("undefined status code");

endmodule
`default_nettype wire

>>> tb/tb_literal_priority_heap_core.sv
// Self-checking testbench for the literal priority heap core, using directed words and random words.
`default_nettype none
module tb_literal_priority_heap_core;
    timeunit 1ns;
    timeprecision 1ps;
    import lph_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [PRIO_W-1:0] PRIO_MAX = '1;

    typedef struct packed {
        logic [LITV_W-1:0] top;
        logic [STS_W-1:0]  status;
        logic [PRIO_W-1:0] prio;
        logic              removed;
        logic [CNT_W-1:0]  active;
    } heap_reply_t;

    typedef struct {
        logic [OP_W-1:0] op;
        int              lit;
        bit              typed;
        heap_reply_t     reply;
    } heap_case_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CIDX_W-1:0] cfg_wr_index = '0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [STS_W-1:0] m_tuser;

    literal_priority_heap_core i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #4 aclk = ~aclk;

    // Heap shadow state.
    int                slot_lit [0:NLIT];
    int                lit_slot [0:NLIT-1];
    logic [PRIO_W-1:0] weight [0:NLIT-1];
    bit                pulled [0:NLIT-1];
    logic [TOTAL_W-1:0] weight_sum;
    int                live;
    int                vars;
    logic [31:0]       factor;
    logic [15:0]       limit;
    logic [15:0]       floor_frac;

    heap_reply_t pending_replies[$];
    int  mismatches = 0;
    int  words_sent = 0;
    int  words_seen = 0;
    int  rescales = 0;
    bit  calm = 1'b0;

    function automatic logic [63:0] scaled(input logic [63:0] a, input logic [63:0] b,
                                           input logic [63:0] c, input logic [63:0] top);
        logic [127:0] q;
        q = ({64'd0, a} * {64'd0, b}) / {64'd0, c};
        return (q > {64'd0, top}) ? top : q[63:0];
    endfunction

    function automatic logic [TOTAL_W-1:0] add_sat(input logic [TOTAL_W-1:0] a,
                                                   input logic [TOTAL_W-1:0] b);
        return (a > TOTAL_MAX - b) ? TOTAL_MAX : a + b;
    endfunction

    function automatic bit orders_below(input int a, input int b);
        if (pulled[a] != pulled[b]) return pulled[a];
        if (!pulled[a]) return weight[a] < weight[b];
        return weight[a] > weight[b];
    endfunction

    function automatic void trade(input int s, input int t);
        int x, y;
        x = slot_lit[s];
        y = slot_lit[t];
        slot_lit[s] = y;
        slot_lit[t] = x;
        lit_slot[x] = t;
        lit_slot[y] = s;
    endfunction

    function automatic void float_up(input int pos);
        while (pos > 1 && orders_below(slot_lit[pos / 2], slot_lit[pos])) begin
            trade(pos / 2, pos);
            pos = pos / 2;
        end
    endfunction

    function automatic void sink(input int pos);
        int l, best;
        forever begin
            l = 2 * pos;
            if (l > 2 * vars) break;
            best = l;
            if (l + 1 <= 2 * vars && orders_below(slot_lit[l], slot_lit[l + 1])) best = l + 1;
            if (!orders_below(slot_lit[pos], slot_lit[best])) break;
            trade(pos, best);
            pos = best;
        end
    endfunction

    function automatic void rebalance();
        logic [TOTAL_W-1:0] target, acc;
        target = TOTAL_W'(limit) << 16;
        acc = '0;
        if (!(weight_sum < TOTAL_W'(floor_frac) || weight_sum > target)) return;
        if (weight_sum == '0) return;
        rescales++;
        for (int i = 0; i < 2 * vars; i++) begin
            weight[i] = PRIO_W'(scaled(64'(weight[i]), 64'(target), 64'(weight_sum),
                                       64'(PRIO_MAX)));
            acc = add_sat(acc, TOTAL_W'(weight[i]));
        end
        weight_sum = acc;
    endfunction

    function automatic void clear_heap();
        for (int i = 0; i < NLIT; i++) begin
            slot_lit[i + 1] = i;
            lit_slot[i] = i + 1;
            weight[i] = '0;
            pulled[i] = 1'b0;
        end
        weight_sum = '0;
        live = 2 * vars;
    endfunction

    function automatic void apply_register(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
        case (idx)
            CFG_VAR_COUNT: begin
                vars = (val[8:0] == 0) ? 1 : (val[8:0] > MAX_VARS) ? MAX_VARS : int'(val[8:0]);
                clear_heap();
            end
            CFG_BUMP_FACTOR: factor = val;
            CFG_BALANCE_LIMIT: limit = val[15:0];
            default: floor_frac = val[15:0];
        endcase
    endfunction

    function automatic heap_reply_t heap_step(input logic [OP_W-1:0] op,
                                              input logic [LITV_W-1:0] raw);
        heap_reply_t r;
        int mag, idx, top;
        bit named;
        logic [PRIO_W-1:0] old;
        mag = raw[9] ? 1024 - int'(raw) : int'(raw);
        named = 1'b0;
        idx = 0;
        r.status = STS_DONE;
        if (op == OP_BUILD) begin
            rebalance();
            for (int i = vars; i >= 1; i--) sink(i);
        end else if (op > OP_BUMP) begin
            r.status = STS_IGNORED;
        end else if (mag == 0 || mag > vars) begin
            r.status = STS_RANGE;
        end else begin
            idx = 2 * (mag - 1) + (raw[9] ? 1 : 0);
            named = 1'b1;
            case (op)
                OP_LOAD: begin
                    weight[idx] = (weight[idx] > PRIO_MAX - ONE_FIX) ? PRIO_MAX
                                                                     : weight[idx] + ONE_FIX;
                    weight_sum = add_sat(weight_sum, TOTAL_W'(ONE_FIX));
                end
                OP_EXTRACT: begin
                    if (pulled[idx]) r.status = STS_IGNORED;
                    else begin
                        pulled[idx] = 1'b1;
                        sink(lit_slot[idx]);
                        live--;
                    end
                end
                OP_RESTORE: begin
                    if (!pulled[idx]) r.status = STS_IGNORED;
                    else begin
                        pulled[idx] = 1'b0;
                        float_up(lit_slot[idx]);
                        live++;
                    end
                end
                default: begin
                    old = weight[idx];
                    weight[idx] = PRIO_W'(scaled(64'(old), 64'(factor), 64'd65536,
                                                 64'(PRIO_MAX)));
                    weight_sum = (weight_sum > TOTAL_W'(old)) ? weight_sum - TOTAL_W'(old) : '0;
                    weight_sum = add_sat(weight_sum, TOTAL_W'(weight[idx]));
                    float_up(lit_slot[idx]);
                    sink(lit_slot[idx]);
                    rebalance();
                end
            endcase
        end
        top = slot_lit[1] / 2 + 1;
        r.top = slot_lit[1][0] ? LITV_W'(-top) : LITV_W'(top);
        r.prio = named ? weight[idx] : '0;
        r.removed = named && pulled[idx];
        r.active = CNT_W'(live);
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= calm || ($urandom_range(99) >= 29);
    end

    always @(posedge aclk) begin
        heap_reply_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.top = m_tdata[9:0];
            got.prio = m_tdata[41:10];
            got.removed = m_tdata[42];
            got.active = m_tdata[52:43];
            got.status = m_tuser;
            words_seen++;
            if (pending_replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result word: %p", got);
            end else begin
                want = pending_replies.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch on word %0d: expected %p, got %p",
                                 words_seen, want, got);
                end
            end
        end
    end

    task automatic send_word(input logic [OP_W-1:0] op, input int lit, input bit typed,
                             input heap_reply_t reply);
        heap_reply_t guess;
        if (!calm && $urandom_range(99) < 29) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= S_DATA_W'(LITV_W'(lit));
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        guess = heap_step(op, LITV_W'(lit));
        pending_replies.push_back(typed ? reply : guess);
        words_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic set_registers(input int vc, input logic [31:0] fac,
                                 input logic [15:0] lim, input logic [15:0] flo);
        logic [CFG_W-1:0] vals [4];
        vals = '{CFG_W'(vc), fac, CFG_W'(lim), CFG_W'(flo)};
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_wr_index <= CIDX_W'(i);
            cfg_wr_data <= vals[i];
            apply_register(cfg_idx_t'(i), vals[i]);
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_words(input int count);
        heap_reply_t none;
        logic [OP_W-1:0] op;
        int pick, lit;
        none = '0;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 38) op = OP_LOAD;
            else if (pick < 46) op = OP_BUILD;
            else if (pick < 62) op = OP_EXTRACT;
            else if (pick < 78) op = OP_RESTORE;
            else if (pick < 95) op = OP_BUMP;
            else op = OP_W'($urandom_range(7, 5));
            if ($urandom_range(99) < 88) begin
                lit = $urandom_range(vars, 1);
                if ($urandom_range(1)) lit = -lit;
            end else begin
                lit = int'($signed(LITV_W'($urandom_range(1023))));
            end
            send_word(op, lit, 1'b0, none);
        end
    endtask

    heap_case_t opening [$];

    function automatic heap_case_t row(input logic [OP_W-1:0] op, input int lit, input bit typed,
                                       input logic [STS_W-1:0] sts);
        heap_case_t c;
        c.op = op;
        c.lit = lit;
        c.typed = typed;
        c.reply = '{top: LITV_W'(1), status: sts, prio: '0, removed: 1'b0,
                    active: CNT_W'(512)};
        return c;
    endfunction

    initial begin
        vars = MAX_VARS;
        factor = 32'd68813;
        limit = 16'd65535;
        floor_frac = 16'd1;
        clear_heap();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        opening = '{
            row(OP_SPARE5, 1, 1, STS_IGNORED), row(OP_SPARE6, -256, 1, STS_IGNORED),
            row(OP_SPARE7, 511, 1, STS_IGNORED), row(OP_LOAD, 0, 1, STS_RANGE),
            row(OP_EXTRACT, 300, 1, STS_RANGE), row(OP_BUMP, -300, 1, STS_RANGE),
            row(OP_RESTORE, -512, 1, STS_RANGE), row(OP_LOAD, 511, 1, STS_RANGE),
            row(OP_BUMP, 2, 0, STS_DONE), row(OP_LOAD, 1, 0, STS_DONE),
            row(OP_LOAD, 1, 0, STS_DONE), row(OP_LOAD, -3, 0, STS_DONE),
            row(OP_LOAD, 256, 0, STS_DONE), row(OP_LOAD, -256, 0, STS_DONE),
            row(OP_BUILD, 5, 0, STS_DONE), row(OP_EXTRACT, 1, 0, STS_DONE),
            row(OP_EXTRACT, 1, 0, STS_DONE), row(OP_LOAD, 1, 0, STS_DONE),
            row(OP_RESTORE, 1, 0, STS_DONE), row(OP_RESTORE, 1, 0, STS_DONE),
            row(OP_BUMP, -3, 0, STS_DONE), row(OP_EXTRACT, -256, 0, STS_DONE),
            row(OP_BUMP, -256, 0, STS_DONE), row(OP_BUILD, 0, 0, STS_DONE)
        };
        foreach (opening[i]) send_word(opening[i].op, opening[i].lit, opening[i].typed,
                                       opening[i].reply);
        random_words(40);
        drain();

        set_registers(0, 32'd0, 16'd1, 16'd0);
        random_words(50);
        drain();
        set_registers(8, 32'hFFFF_FFFF, 16'd1, 16'd65535);
        random_words(80);
        drain();
        calm = 1'b1;
        set_registers(20, 32'd131072, 16'd3, 16'd65535);
        random_words(80);
        drain();
        calm = 1'b0;
        set_registers(511, 32'd98304, 16'd65535, 16'd1);
        random_words(50);
        drain();
        set_registers(5, 32'd32768, 16'd2, 16'd300);
        random_words(80);
        drain();

        $display("Covered %0d words in six register settings, %0d rescales, %0d results.",
                 words_sent, rescales, words_seen);
        if (mismatches == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("Timeout with %0d results outstanding.", pending_replies.size());
        $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
